FILE: hw/rtl/tsm_pkg.sv
// Shared types and constants for the tone synth mixer.
// Holds the per-channel state record, command and waveform codes and the sine table.
// No dependencies.
package tsm_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 56;

  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam int          SAMPLE_MAX = 32767;
  localparam int          SAMPLE_MIN = -32768;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_START    = 3'd1,
    MODE_STOP     = 3'd2,
    MODE_STOP_ALL = 3'd3,
    MODE_PAUSE    = 3'd4,
    MODE_RESUME   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    WF_SINE     = 3'd0,
    WF_SQUARE   = 3'd1,
    WF_SAW      = 3'd2,
    WF_TRIANGLE = 3'd3,
    WF_NOISE    = 3'd4
  } wave_e;

  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] step;
    logic [23:0] countdown;
    logic        infinite;
    wave_e       wave;
    logic [15:0] noise;
  } chan_entry_t;

  typedef struct packed {
    logic clr;
    logic samp_v;
    logic ld;
  } mix_ctl_t;

  typedef logic [255:0][15:0] sine_rom_t;

  // quarter wave, Q30 Taylor series
  function automatic logic [15:0] sine_quarter(input int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] v;
    longint      s;
    if (k == 0) return 16'd0;
    if (k == 64) return 16'(SAMPLE_MAX);
    x = (PI_Q30 * 64'(k)) >> 7;
    s = longint'(x);
    t = x;
    for (int n = 1; n <= 10; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    v = (64'(s) * 64'd32767) >> 30;
    return v[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   r;
    logic [15:0] v;
    r = '0;
    for (int k = 0; k <= 64; k++) begin
      v = sine_quarter(k);
      r[k]       = v;
      r[128 - k] = v;
      r[128 + k] = 16'(-v);
      if (k > 0) r[256 - k] = 16'(-v);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hw/rtl/tsm_chan_mem.sv
// Channel state memory: one record per channel, one write and one read port.
// Read data is registered and appears in the cycle after the read. Uses tsm_pkg.
module tsm_chan_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  tsm_pkg::chan_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output tsm_pkg::chan_entry_t rdata_o
);
  import tsm_pkg::*;

  chan_entry_t mem_q [DEPTH];
  chan_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tsm_voice.sv
// Per-channel voice update: waveform sample, LFSR step, phase and countdown.
// Combinational, fed from the channel memory read port. Uses tsm_pkg.
module tsm_voice (
  input  tsm_pkg::chan_entry_t entry_i,
  input  logic                 on_i,
  output tsm_pkg::chan_entry_t entry_o,
  output logic                 on_o,
  output logic signed [15:0]   sample_o
);
  import tsm_pkg::*;

  logic [31:0] p;
  logic [31:0] prev;
  logic [15:0] lfsr_nxt;
  logic        fb;
  logic [15:0] samp;

  assign p    = entry_i.phase;
  assign prev = p - entry_i.step;
  assign fb   = entry_i.noise[0] ^ entry_i.noise[1] ^ entry_i.noise[5] ^ entry_i.noise[6];

  always_comb begin
    entry_o  = entry_i;
    on_o     = on_i;
    lfsr_nxt = entry_i.noise;
    if (p[31:24] != prev[31:24]) begin
      lfsr_nxt = {fb, entry_i.noise[15:1]};
    end
    case (entry_i.wave)
      WF_SINE:     samp = SINE_ROM[p[31:24]];
      WF_SQUARE:   samp = p[31] ? 16'(SAMPLE_MAX) : 16'(-SAMPLE_MAX);
      WF_SAW:      samp = {~p[31], p[30:16]};
      WF_TRIANGLE: samp = p[31] ? {p[30], ~p[29:15]} : {~p[30], p[29:15]};
      WF_NOISE: begin
        samp          = {~lfsr_nxt[15], lfsr_nxt[14:0]};
        entry_o.noise = lfsr_nxt;
      end
      default:     samp = 16'd0;
    endcase
    entry_o.phase = p + entry_i.step;
    if (!entry_i.infinite && (entry_i.countdown != 24'd0)) begin
      entry_o.countdown = entry_i.countdown - 24'd1;
      if (entry_i.countdown == 24'd1) on_o = 1'b0;
    end
    if (!on_i) begin
      samp = 16'd0;
    end
  end

  assign sample_o = samp;

endmodule

FILE: hw/rtl/tsm_mix.sv
// Mixer: registers voice samples, accumulates, clips to 16 bits and holds the
// output item until the receiver takes it. Uses tsm_pkg.
module tsm_mix #(
  parameter int MIX_W = 19
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsm_pkg::mix_ctl_t           ctl_i,
  input  logic signed [15:0]          sample_i,
  input  logic [3:0]                  mask_i,
  output logic                        busy_o,
  output logic                        free_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [tsm_pkg::OUT_TDATA_W-1:0] m_data_o
);
  import tsm_pkg::*;

  localparam logic signed [MIX_W-1:0] ACC_MAX = MIX_W'(SAMPLE_MAX);
  localparam logic signed [MIX_W-1:0] ACC_MIN = MIX_W'(SAMPLE_MIN);

  logic                    samp_v_q;
  logic signed [15:0]      samp_q;
  logic signed [MIX_W-1:0] acc_q, acc_d;
  logic [15:0]             sat;
  logic                    valid_q, valid_d;
  logic [OUT_TDATA_W-1:0]  data_q;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (samp_v_q) begin
      acc_d = acc_q + MIX_W'(samp_q);
    end
    if (acc_q > ACC_MAX) sat = 16'(SAMPLE_MAX);
    else if (acc_q < ACC_MIN) sat = 16'(SAMPLE_MIN);
    else sat = acc_q[15:0];
    valid_d = valid_q;
    if (ctl_i.ld) valid_d = 1'b1;
    else if (m_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_v_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      samp_v_q <= ctl_i.samp_v;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= sample_i;
    acc_q  <= acc_d;
    if (ctl_i.ld) begin
      data_q <= {4'd0, mask_i, sat, sat, sat};
    end
  end

  assign busy_o    = samp_v_q;
  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

FILE: hw/rtl/multichannel_tone_synth_mixer_unit.sv
// Top level of the multichannel tone synth mixer.
// Instantiates tsm_chan_mem, tsm_voice and tsm_mix; uses tsm_pkg.
//
// Input channel s_axis: tuser carries the command, tdata its arguments.
// Output channel m_axis: one item per sample tick, none for other commands.
// Start, stop, stop-all, pause and resume leave ready high, so they can
// follow back to back.
// A sample tick sweeps the channel state memory one channel a cycle through
// its single read port (ST_RUN), waits in ST_WAIT until the voice and mixer
// stages drain, then loads the mixed item in ST_FIN; ready returns in the same
// cycle that the item becomes valid. A tick while paused goes straight to
// ST_FIN and gives a silent item.
// Reset turns every channel off and clears pause; channel records need no
// clearing since a start writes the whole record.
// A finished item waits in the output register; commands are still taken
// meanwhile, but the next tick holds in its last cycle until that register
// is free.
module multichannel_tone_synth_mixer_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // channel_index[3:0], phase_increment[35:4], duration_samples[59:36],
  // wave_select[62:60], zero pad
  input  logic [tsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // mode[2:0]
  input  logic [tsm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mixed_sample[15:0], stereo_word[47:16], active_mask[51:48], zero pad
  output logic [tsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import tsm_pkg::*;

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MIX_W = 17 + AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic                s1_v_q, s1_v_d;
  logic [AW-1:0]       s1_idx_q;
  logic [CHANNELS-1:0] chan_on_q, chan_on_d;
  logic                paused_q, paused_d;

  mode_e        in_mode;
  logic [3:0]   in_idx;
  logic [31:0]  in_inc;
  logic [23:0]  in_dur;
  logic [2:0]   in_wave;
  logic         in_acc;
  logic         idx_ok;
  wave_e        wave_sel;

  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  chan_entry_t  mem_wdata, mem_rdata, voice_nxt;
  logic         voice_on;
  logic signed [15:0] voice_sample;
  mix_ctl_t     mix_ctl;
  logic         mix_busy, mix_free;
  logic [3:0]   mask;

  assign in_mode = mode_e'(s_axis_tuser[2:0]);
  assign in_idx  = s_axis_tdata[3:0];
  assign in_inc  = s_axis_tdata[35:4];
  assign in_dur  = s_axis_tdata[59:36];
  assign in_wave = s_axis_tdata[62:60];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = ({1'b0, in_idx} < 5'(CHANNELS));
  assign wave_sel      = (in_wave > 3'(WF_NOISE)) ? WF_SQUARE : wave_e'(in_wave);

  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    s1_v_d    = 1'b0;
    chan_on_d = chan_on_q;
    paused_d  = paused_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = in_idx[AW-1:0];
    mem_wdata = '{phase: 32'd0, step: in_inc, countdown: in_dur,
                  infinite: (in_dur == 24'd0), wave: wave_sel, noise: LFSR_SEED};
    mix_ctl   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_TICK: begin
              mix_ctl.clr = 1'b1;
              rd_idx_d    = '0;
              state_d     = paused_q ? ST_FIN : ST_RUN;
            end
            MODE_START: begin
              if (idx_ok && (in_inc != 32'd0)) begin
                mem_we                    = 1'b1;
                chan_on_d[in_idx[AW-1:0]] = 1'b1;
              end
            end
            MODE_STOP: begin
              if (idx_ok) chan_on_d[in_idx[AW-1:0]] = 1'b0;
            end
            MODE_STOP_ALL: chan_on_d = '0;
            MODE_PAUSE:    paused_d  = 1'b1;
            MODE_RESUME:   paused_d  = 1'b0;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        mem_re = 1'b1;
        s1_v_d = 1'b1;
        if (rd_idx_q == AW'(CHANNELS - 1)) state_d = ST_WAIT;
        else rd_idx_d = rd_idx_q + AW'(1);
      end
      ST_WAIT: begin
        if (!s1_v_q && !mix_busy) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (mix_free) begin
          mix_ctl.ld = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (s1_v_q) begin
      mix_ctl.samp_v      = 1'b1;
      chan_on_d[s1_idx_q] = voice_on;
      mem_we              = chan_on_q[s1_idx_q];
      mem_waddr           = s1_idx_q;
      mem_wdata           = voice_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_idx_q  <= '0;
      s1_v_q    <= 1'b0;
      chan_on_q <= '0;
      paused_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      s1_v_q    <= s1_v_d;
      chan_on_q <= chan_on_d;
      paused_q  <= paused_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_idx_q;
  end

  for (genvar gi = 0; gi < 4; gi++) begin : g_mask
    if (gi < CHANNELS) begin : g_on
      assign mask[gi] = chan_on_q[gi];
    end else begin : g_off
      assign mask[gi] = 1'b0;
    end
  end

  tsm_chan_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  tsm_voice u_voice (
    .entry_i  (mem_rdata),
    .on_i     (chan_on_q[s1_idx_q]),
    .entry_o  (voice_nxt),
    .on_o     (voice_on),
    .sample_o (voice_sample)
  );

  tsm_mix #(
    .MIX_W (MIX_W)
  ) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mix_ctl),
    .sample_i  (voice_sample),
    .mask_i    (mask),
    .busy_o    (mix_busy),
    .free_o    (mix_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_FIN)
    else $error("output item raised outside the final tick cycle");

  a_s1_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (state_q == ST_RUN || state_q == ST_WAIT))
    else $error("voice stage active outside a tick sweep");

  a_no_start_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> (chan_on_q & ~$past(chan_on_q)) == '0)
    else $error("channel switched on during a tick");

  a_paused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mix_ctl.ld && paused_q) |=> m_axis_tdata[47:0] == '0)
    else $error("paused tick gave a non-zero sample");

endmodule
